// ----- src/qfr_pkg.sv -----
// ----------------------------------------------------------------------------
// qfr_pkg: shared types for the rotation matrix to quaternion converter
// Beat structures for both channels, the control word that travels along the
// cell chain, and the default fixed-point format.
// ----------------------------------------------------------------------------
package qfr_pkg;

  localparam int FRAC_BITS_DEF = 14;

  typedef struct packed {
    logic signed [15:0] r1c1;
    logic signed [15:0] r1c2;
    logic signed [15:0] r1c3;
    logic signed [15:0] r2c1;
    logic signed [15:0] r2c2;
    logic signed [15:0] r2c3;
    logic signed [15:0] r3c1;
    logic signed [15:0] r3c2;
    logic signed [15:0] r3c3;
  } qfr_in_t;

  typedef struct packed {
    logic        [14:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } qfr_out_t;

  // Valid flag and the three vector signs, carried beside the data.
  typedef struct packed {
    logic       vld;
    logic [2:0] neg;
  } qfr_ctl_t;

endpackage

// ----- src/quaternion_from_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// quaternion_from_rotation_matrix: 3x3 rotation matrix to unit quaternion
// Converts nine signed fixed-point matrix entries into w, x, y and z.
// ----------------------------------------------------------------------------
// Use: one matrix enters per input beat on in_valid/in_stall/in_data, and one
// quaternion leaves per output beat on out_valid/out_stall/out_data. Both
// channels complete a beat on a rising edge with valid high and stall low.
// Throughput is one beat per cycle unless the receiver stalls a result. The
// registered stages are, in order: one front stage forming the diagonal
// combinations and their sum, 2*FRAC_BITS+1 division cells producing one
// quotient bit each, FRAC_BITS+1 square root cells producing one root bit
// each, and the output register. FRAC_BITS defaults to 14 fraction bits.
// The whole chain advances together; when a result sits in the output
// register and the receiver stalls, the chain holds and in_stall is raised,
// otherwise a new beat is taken every cycle. Reset clears every valid flag,
// so the block comes out of reset empty and ready; no clearing pass exists.
// ----------------------------------------------------------------------------
module quaternion_from_rotation_matrix #(
  parameter int FRAC_BITS = qfr_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  qfr_pkg::qfr_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output qfr_pkg::qfr_out_t out_data
);
  import qfr_pkg::*;

  // Working widths follow from the fraction bit count.
  localparam int DW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int SW = DW + 2;
  localparam int RW = SW + 1;
  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int NB = FRAC_BITS + 1;
  localparam int NW = 2 * NB;
  localparam int EW = NB + 2;
  localparam int ND = QW;
  localparam int NS = NB;

  localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;

  logic en;

  // The chain moves as one unless the output beat is held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Front stage: sign-extend the entries and form the four combinations.
  logic signed [DW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  logic signed [DW-1:0] ca, cb, cc, cd;
  logic [3:0][DW-1:0]   mag;
  logic [SW-1:0]        sum;
  logic [2:0]           neg;

  always_comb begin
    m11 = DW'(in_data.r1c1);
    m12 = DW'(in_data.r1c2);
    m13 = DW'(in_data.r1c3);
    m21 = DW'(in_data.r2c1);
    m22 = DW'(in_data.r2c2);
    m23 = DW'(in_data.r2c3);
    m31 = DW'(in_data.r3c1);
    m32 = DW'(in_data.r3c2);
    m33 = DW'(in_data.r3c3);
    ca = ONE + m11 + m22 + m33;
    cb = ONE + m11 - m22 - m33;
    cc = ONE - m11 + m22 - m33;
    cd = ONE - m11 - m22 + m33;
    mag[0] = ca[DW-1] ? DW'(-ca) : DW'(ca);
    mag[1] = cb[DW-1] ? DW'(-cb) : DW'(cb);
    mag[2] = cc[DW-1] ? DW'(-cc) : DW'(cc);
    mag[3] = cd[DW-1] ? DW'(-cd) : DW'(cd);
    sum = SW'(mag[0]) + SW'(mag[1]) + SW'(mag[2]) + SW'(mag[3]);
    // A zero difference leaves its part positive.
    neg[0] = (m32 - m23) < 0;
    neg[1] = (m13 - m31) < 0;
    neg[2] = (m21 - m12) < 0;
  end

  qfr_ctl_t           front_ctl_r;
  logic [SW-1:0]      front_den_r;
  logic [3:0][DW-1:0] front_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_ctl_r <= '0;
    end else if (en) begin
      front_ctl_r.vld <= in_valid;
      front_ctl_r.neg <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_den_r <= sum;
      front_mag_r <= mag;
    end
  end

  // Division chain: each part over the sum, 2*FRAC_BITS fraction bits.
  qfr_ctl_t           div_ctl [0:ND];
  logic [SW-1:0]      div_den [0:ND];
  logic [3:0][RW-1:0] div_rem [0:ND];
  logic [3:0][QW-1:0] div_quo [0:ND];

  assign div_ctl[0] = front_ctl_r;
  assign div_den[0] = front_den_r;
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      div_rem[0][l] = RW'(front_mag_r[l]);
      div_quo[0][l] = '0;
    end
  end

  for (genvar i = 0; i < ND; i++) begin : g_div
    qfr_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (div_ctl[i]),
      .den_i (div_den[i]),
      .rem_i (div_rem[i]),
      .quo_i (div_quo[i]),
      .ctl_o (div_ctl[i+1]),
      .den_o (div_den[i+1]),
      .rem_o (div_rem[i+1]),
      .quo_o (div_quo[i+1])
    );
  end

  // Square root chain: one root bit per cell, truncated toward zero.
  qfr_ctl_t           sq_ctl [0:NS];
  logic [3:0][NW-1:0] sq_rad [0:NS];
  logic [3:0][EW-1:0] sq_rem [0:NS];
  logic [3:0][NB-1:0] sq_res [0:NS];

  assign sq_ctl[0] = div_ctl[ND];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sq_rad[0][l] = NW'(div_quo[ND][l]);
      sq_rem[0][l] = '0;
      sq_res[0][l] = '0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    qfr_sqrt_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (sq_ctl[i]),
      .rad_i (sq_rad[i]),
      .rem_i (sq_rem[i]),
      .res_i (sq_res[i]),
      .ctl_o (sq_ctl[i+1]),
      .rad_o (sq_rad[i+1]),
      .rem_o (sq_rem[i+1]),
      .res_o (sq_res[i+1])
    );
  end

  // Output register: apply the signs and fit the fixed port widths.
  logic     out_valid_r;
  qfr_out_t out_data_r, out_data_nxt;

  always_comb begin
    logic [15:0] mx, my, mz;
    mx = 16'(sq_res[NS][1]);
    my = 16'(sq_res[NS][2]);
    mz = 16'(sq_res[NS][3]);
    out_data_nxt.quat_w = 15'(sq_res[NS][0]);
    out_data_nxt.quat_x = sq_ctl[NS].neg[0] ? -mx : mx;
    out_data_nxt.quat_y = sq_ctl[NS].neg[1] ? -my : my;
    out_data_nxt.quat_z = sq_ctl[NS].neg[2] ? -mz : mz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_ctl[NS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A held result must not move while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");

  // After reset the chain is empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // The w and x magnitudes never exceed one.
  a_w_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.quat_w <= 15'd16384)
    else $error("quat_w above one");

  a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_x <= 16'sd16384) && (out_data.quat_x >= -16'sd16384))
    else $error("quat_x out of range");
`endif

endmodule

// ----- src/qfr_div_cell.sv -----
// ----------------------------------------------------------------------------
// qfr_div_cell: one restoring division step for four lanes
// Produces one quotient bit per lane against a shared divisor and registers
// the partial remainder and quotient for the next cell.
// ----------------------------------------------------------------------------
module qfr_div_cell #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  qfr_pkg::qfr_ctl_t                      ctl_i,
  input  logic [((FRAC_BITS>17)?FRAC_BITS:17)+4:0] den_i,
  input  logic [3:0][((FRAC_BITS>17)?FRAC_BITS:17)+5:0] rem_i,
  input  logic [3:0][2*FRAC_BITS:0]               quo_i,
  output qfr_pkg::qfr_ctl_t                      ctl_o,
  output logic [((FRAC_BITS>17)?FRAC_BITS:17)+4:0] den_o,
  output logic [3:0][((FRAC_BITS>17)?FRAC_BITS:17)+5:0] rem_o,
  output logic [3:0][2*FRAC_BITS:0]               quo_o
);
  import qfr_pkg::*;

  localparam int DW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int SW = DW + 2;
  localparam int RW = SW + 1;
  localparam int QW = 2 * FRAC_BITS + 1;

  qfr_ctl_t               ctl_r;
  logic [SW-1:0]          den_r;
  logic [3:0][RW-1:0]     rem_r, rem_nxt;
  logic [3:0][QW-1:0]     quo_r, quo_nxt;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      logic          ge;
      logic [RW-1:0] rs;
      ge = rem_i[l] >= {1'b0, den_i};
      rs = ge ? (rem_i[l] - {1'b0, den_i}) : rem_i[l];
      rem_nxt[l] = {rs[RW-2:0], 1'b0};
      quo_nxt[l] = {quo_i[l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

// ----- src/qfr_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// qfr_sqrt_cell: one digit-by-digit square root step for four lanes
// Takes two radicand bits, decides one root bit and registers the result.
// ----------------------------------------------------------------------------
module qfr_sqrt_cell #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  qfr_pkg::qfr_ctl_t             ctl_i,
  input  logic [3:0][2*FRAC_BITS+1:0]   rad_i,
  input  logic [3:0][FRAC_BITS+2:0]     rem_i,
  input  logic [3:0][FRAC_BITS:0]       res_i,
  output qfr_pkg::qfr_ctl_t             ctl_o,
  output logic [3:0][2*FRAC_BITS+1:0]   rad_o,
  output logic [3:0][FRAC_BITS+2:0]     rem_o,
  output logic [3:0][FRAC_BITS:0]       res_o
);
  import qfr_pkg::*;

  localparam int NB = FRAC_BITS + 1;
  localparam int NW = 2 * NB;
  localparam int EW = NB + 2;

  qfr_ctl_t           ctl_r;
  logic [3:0][NW-1:0] rad_r, rad_nxt;
  logic [3:0][EW-1:0] rem_r, rem_nxt;
  logic [3:0][NB-1:0] res_r, res_nxt;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      logic [EW-1:0] r2;
      logic [EW-1:0] t;
      logic          ge;
      r2 = {rem_i[l][EW-3:0], rad_i[l][NW-1:NW-2]};
      t  = {res_i[l], 2'b01};
      ge = r2 >= t;
      rem_nxt[l] = ge ? (r2 - t) : r2;
      res_nxt[l] = {res_i[l][NB-2:0], ge};
      rad_nxt[l] = {rad_i[l][NW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad_nxt;
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rad_o = rad_r;
  assign rem_o = rem_r;
  assign res_o = res_r;

endmodule
